// ===== design/sdlh_pkg.sv =====
// Package for the salted dual-lane string hash: constants, opcode codes and the
// queue entry type shared by the front and back parts. No dependencies.
`timescale 1ns / 1ps
package sdlh_pkg;
  localparam logic [63:0] KeySeed   = 64'hcbf29ce484222325;
  localparam logic [63:0] ValueSeed = 64'h84222325cbf29ce4;
  localparam logic [63:0] MixPrime  = 64'h00000100000001b3;
  localparam int unsigned HashBytesDefault = 32;
  localparam int unsigned CmdDepth = 2;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_VALUE  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [63:0] nonce;
  } cmd_t;

  // Multiply by the prime 2^40 + 0x1b3 as a shift plus a narrow product.
  function automatic logic [63:0] mul_prime(input logic [63:0] x);
    logic [63:0] lo;
    lo = x * 64'h1b3;
    return lo + {x[23:0], 40'd0};
  endfunction
endpackage

// ===== design/sdlh_front.sv =====
// Front part: takes input transfers, drops the unused opcode and queues the
// rest for the back part. Depends on sdlh_pkg.
`timescale 1ns / 1ps
module sdlh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    data_byte_i,
  input  logic [63:0]   nonce_i,
  output logic          cmd_valid_o,
  output sdlh_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import sdlh_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t             mem_q [CmdDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             wr_en, rd_en, keep;

  assign full        = (cnt_q == (PtrW+1)'(CmdDepth));
  assign keep        = (op_e'(opcode_i) != OP_NONE);
  assign wr_en       = push && !full && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= '{op: op_e'(opcode_i), data: data_byte_i, nonce: nonce_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= (wr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_q + 1'b1;
      if (rd_en) rd_q <= (rd_q == PtrW'(CmdDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(CmdDepth))
    else $error("command queue overflow");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !wr_en)
    else $error("write while full");
  a_empty_no_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !cmd_valid_o)
    else $error("valid from empty queue");
endmodule

// ===== design/sdlh_back.sv =====
// Back part: lane absorption, finish mixing and hash byte output through a
// one-entry output register. Depends on sdlh_pkg.
`timescale 1ns / 1ps
module sdlh_back #(
  parameter int unsigned HashBytes = sdlh_pkg::HashBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sdlh_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [63:0]    cfg_data_i,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     hash_byte_o,
  output logic [5:0]     byte_index_o,
  output logic           last_o
);
  import sdlh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ABS_MUL, S_ABS_SH, S_RND_ADD, S_RND_MUL, S_OUT_SH, S_OUT_MUL, S_OUT_EMIT
  } state_e;

  state_e      state_q;
  logic [63:0] salt_q, a_q, b_q, m_q;
  logic [31:0] klen_q, vlen_q;
  logic        is_val_q;
  logic [2:0]  rnd_q;
  logic [5:0]  idx_q;
  logic [2:0]  mod7_q;
  logic        ovalid_q;
  logic [7:0]  obyte_q;
  logic [5:0]  oidx_q;
  logic        olast_q;
  logic [63:0] lane, m_x, m_s, a1, b1, a2, b2;
  logic [5:0]  shamt;
  logic        emit_go;

  // A salt write takes priority, so no command is taken in the same cycle.
  assign cmd_ready_o = (state_q == S_IDLE) && !cfg_valid;
  assign cfg_ready   = (state_q == S_IDLE);
  assign empty       = !ovalid_q;
  assign hash_byte_o  = obyte_q;
  assign byte_index_o = oidx_q;
  assign last_o       = olast_q;
  assign emit_go      = (state_q == S_OUT_EMIT) && (!ovalid_q || pop);

  always_comb begin
    lane  = is_val_q ? b_q : a_q;
    shamt = 6'd13 + {3'd0, mod7_q};
    m_x   = idx_q[0] ? b_q : a_q;
    m_s   = m_x ^ (m_x >> shamt);
    a1 = a_q + (b_q ^ (a_q >> 17));
    b1 = b_q + (a1 ^ (b_q >> 13));
    a2 = a1 ^ (a1 << 41);
    b2 = b1 ^ (b1 << 37);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      salt_q   <= '0;
      a_q      <= KeySeed;
      b_q      <= ~ValueSeed;
      klen_q   <= '0;
      vlen_q   <= '0;
      ovalid_q <= 1'b0;
      is_val_q <= 1'b0;
      rnd_q    <= '0;
      idx_q    <= '0;
      mod7_q   <= '0;
      m_q      <= '0;
      obyte_q  <= '0;
      oidx_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      if (emit_go) ovalid_q <= 1'b1;
      else if (pop && ovalid_q) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid) begin
            salt_q <= cfg_data_i;
            a_q    <= KeySeed ^ cfg_data_i;
            b_q    <= ValueSeed ^ ~cfg_data_i;
            klen_q <= '0;
            vlen_q <= '0;
          end else if (cmd_valid_i) begin
            unique case (cmd_i.op)
              OP_KEY: begin
                a_q <= a_q ^ {56'd0, cmd_i.data};
                is_val_q <= 1'b0;
                klen_q <= klen_q + 32'd1;
                state_q <= S_ABS_MUL;
              end
              OP_VALUE: begin
                b_q <= b_q ^ {56'd0, cmd_i.data};
                is_val_q <= 1'b1;
                vlen_q <= vlen_q + 32'd1;
                state_q <= S_ABS_MUL;
              end
              OP_FINISH: begin
                a_q <= a_q ^ cmd_i.nonce ^ {klen_q, 32'd0};
                b_q <= b_q ^ ~cmd_i.nonce ^ {16'd0, vlen_q, 16'd0};
                rnd_q <= '0;
                state_q <= S_RND_ADD;
              end
              default: ;
            endcase
          end
        end
        S_ABS_MUL: begin
          m_q <= mul_prime(lane);
          state_q <= S_ABS_SH;
        end
        S_ABS_SH: begin
          if (is_val_q) b_q <= (m_q ^ (m_q >> 29)) ^ ((m_q ^ (m_q >> 29)) << 31);
          else          a_q <= (m_q ^ (m_q >> 27)) ^ ((m_q ^ (m_q >> 27)) << 33);
          state_q <= S_IDLE;
        end
        S_RND_ADD: begin
          a_q <= a2;
          b_q <= b2;
          state_q <= S_RND_MUL;
        end
        S_RND_MUL: begin
          a_q <= mul_prime(a_q);
          b_q <= mul_prime(b_q);
          rnd_q <= rnd_q + 3'd1;
          if (rnd_q == 3'd5) begin
            idx_q <= '0;
            mod7_q <= '0;
            state_q <= S_OUT_SH;
          end else begin
            state_q <= S_RND_ADD;
          end
        end
        S_OUT_SH: begin
          m_q <= m_s;
          state_q <= S_OUT_MUL;
        end
        S_OUT_MUL: begin
          m_q <= mul_prime(m_q) ^ salt_q;
          state_q <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (emit_go) begin
            obyte_q  <= m_q[8*idx_q[2:0] +: 8];
            oidx_q   <= idx_q;
            olast_q  <= (idx_q == 6'(HashBytes - 1));
            if (idx_q == 6'(HashBytes - 1)) begin
              a_q <= KeySeed ^ salt_q;
              b_q <= ValueSeed ^ ~salt_q;
              klen_q <= '0;
              vlen_q <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q  <= idx_q + 6'd1;
              mod7_q <= (mod7_q == 3'd6) ? 3'd0 : mod7_q + 3'd1;
              state_q <= S_OUT_SH;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 3'd6)
    else $error("round count out of range");
  a_mod7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod7_q <= 3'd6)
    else $error("index modulo out of range");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !pop) |=> ovalid_q && $stable(obyte_q))
    else $error("waiting result lost");
endmodule

// ===== design/salted_dual_lane_string_hash_top.sv =====
// Top level of the salted dual-lane string hash.
// Depends on sdlh_pkg, sdlh_front and sdlh_back.
`timescale 1ns / 1ps
// A string byte passes the back xor, prime multiply and two xorshifts after
// its queue transfer; a finish runs the add and multiply rounds, then shift,
// multiply and emit per hash byte, HashBytes results in index order, the
// last one marked. The lane multiply is the limit. A two-entry queue sits
// between front and back. Salt writes reseed the lanes, are taken only while
// the back part is idle, and should be made only while no item is in flight.
module salted_dual_lane_string_hash_top #(
  parameter int unsigned HashBytes = sdlh_pkg::HashBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [63:0] nonce_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  hash_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);
  import sdlh_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  sdlh_front u_front (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .data_byte_i, .nonce_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  sdlh_back #(.HashBytes(HashBytes)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .cfg_valid, .cfg_ready, .cfg_data_i, .empty, .pop,
    .hash_byte_o, .byte_index_o, .last_o
  );
endmodule
